FILE: rtl/sglr_pkg.sv
// ----------------------------------------------------------------------------
// sglr_pkg
// Shared types and constants for the servo group linear ramp.
// ----------------------------------------------------------------------------
package sglr_pkg;

    localparam int CMD_W  = 3;
    localparam int IDX_W  = 4;
    localparam int ANG_W  = 8;
    localparam int DUR_W  = 12;

    // k * (target - start): 13-bit unsigned step times 9-bit signed difference
    localparam int DIFF_W = ANG_W + 1;
    localparam int PROD_W = DUR_W + 1 + DIFF_W;
    // |k * diff| <= 4095 * 255, so 20 bits hold the magnitude
    localparam int MAG_W  = 20;
    // the quotient never exceeds |diff| <= 255
    localparam int QUO_W  = ANG_W;

    localparam int NUM_SERVOS_DEF = 16;
    localparam int GROUP_SIZE_DEF = 8;

    localparam logic [CMD_W-1:0] CMD_SET   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] servo_index;
        logic [ANG_W-1:0] angle;
        logic [DUR_W-1:0] duration_ticks;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0] out_servo;
        logic [ANG_W-1:0] out_angle;
        logic             is_read;
        logic             last;
    } res_t;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [DUR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
        logic             rem_nz;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUT,
        ST_READ,
        ST_RD,
        ST_MUL,
        ST_ABS,
        ST_DIV,
        ST_OUT,
        ST_COMMIT,
        ST_JUMP
    } state_t;

endpackage

FILE: rtl/sglr_ram.sv
// ----------------------------------------------------------------------------
// sglr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sglr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/sglr_div.sv
// ----------------------------------------------------------------------------
// sglr_div
// Restoring divider, one quotient bit per cycle. The caller guarantees the
// quotient fits in QUO_W bits, so only QUO_W steps are run.
// ----------------------------------------------------------------------------
module sglr_div (
    input  logic                clk,
    input  logic                rst_n,
    input  sglr_pkg::div_req_t  req,
    output sglr_pkg::div_rsp_t  rsp
);
    import sglr_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic             busy_reg,  busy_next;
    logic             done_reg,  done_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [DUR_W-1:0] rem_reg,   rem_next;
    logic [QUO_W-1:0] low_reg,   low_next;
    logic [DUR_W-1:0] dvs_reg,   dvs_next;

    logic [DUR_W:0]   rem_shift;
    logic             ge;

    always_comb
    begin
        rem_shift = {rem_reg, low_reg[QUO_W-1]};
        ge        = rem_shift >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            // upper part is already below the divisor
            rem_next  = DUR_W'(req.dividend[MAG_W-1:QUO_W]);
            low_next  = req.dividend[QUO_W-1:0];
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DUR_W'(rem_shift - {1'b0, dvs_reg}) : DUR_W'(rem_shift);
            low_next = {low_reg[QUO_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = low_reg;
    assign rsp.rem_nz   = (rem_reg != '0);

endmodule

FILE: rtl/servo_group_linear_ramp.sv
// ----------------------------------------------------------------------------
// servo_group_linear_ramp
// Per-servo angle store with a pending group that ramps linearly over ticks.
// A tick takes each group member through ST_RD, ST_MUL, ST_ABS, the 8-step
// shared divider and ST_OUT; a final tick then stores the targets in
// ST_COMMIT. A jump start writes and reports each member in ST_JUMP. One
// command at a time. Reset clears control state and marks every angle as
// zero; no clearing pass is run.
// ----------------------------------------------------------------------------
module servo_group_linear_ramp #(
    parameter int NUM_SERVOS = sglr_pkg::NUM_SERVOS_DEF,
    parameter int GROUP_SIZE = sglr_pkg::GROUP_SIZE_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  sglr_pkg::cmd_t  cmd_data,
    output logic            res_valid,
    input  logic            res_stall,
    output sglr_pkg::res_t  res_data
);
    import sglr_pkg::*;

    localparam int SRV_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
    localparam int GRP_W = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
    localparam int CNT_W = $clog2(GROUP_SIZE + 1);

    state_t            state_reg, state_next;
    logic              moving_reg, moving_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [CNT_W-1:0]  ptr_reg,    ptr_next;
    logic [DUR_W-1:0]  step_reg,   step_next;
    logic [DUR_W-1:0]  total_reg,  total_next;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg,    res_next;
    res_t              pend_reg,   pend_next;
    logic [ANG_W-1:0]  start_reg,  start_next;
    logic [PROD_W-1:0] prod_reg,   prod_next;
    logic              neg_reg,    neg_next;
    logic [NUM_SERVOS-1:0] pvalid_reg;
    logic              rd_valid_reg;

    logic [SRV_W-1:0]  mem_servo_reg  [GROUP_SIZE];
    logic [ANG_W-1:0]  mem_target_reg [GROUP_SIZE];

    logic              add_en;
    logic              ram_we;
    logic [SRV_W-1:0]  ram_waddr;
    logic [ANG_W-1:0]  ram_wdata;
    logic [SRV_W-1:0]  ram_raddr;
    logic [ANG_W-1:0]  ram_rdata;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic              accept;
    logic              out_free;
    logic              idx_ok;
    logic [SRV_W-1:0]  cmd_srv;
    logic [GRP_W-1:0]  cur;
    logic              cur_last;
    logic [ANG_W-1:0]  rd_angle;
    logic [DUR_W-1:0]  step_inc;

    assign accept   = cmd_valid && !cmd_stall;
    assign out_free = !res_valid_reg || !res_stall;
    assign idx_ok   = 32'(cmd_data.servo_index) < NUM_SERVOS;
    assign cmd_srv  = SRV_W'(cmd_data.servo_index);
    assign cur      = ptr_reg[GRP_W-1:0];
    assign cur_last = (ptr_reg + 1'b1) == count_reg;
    assign rd_angle = rd_valid_reg ? ram_rdata : '0;
    assign step_inc = step_reg + 1'b1;

    sglr_ram #(
        .WIDTH (ANG_W),
        .DEPTH (NUM_SERVOS),
        .AW    (SRV_W)
    ) u_angle_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sglr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        logic signed [DIFF_W-1:0] diff;
        logic        [MAG_W-1:0]  mag;
        logic        [ANG_W:0]    val;

        diff           = $signed({1'b0, mem_target_reg[cur]}) - $signed({1'b0, rd_angle});
        mag            = neg_reg ? MAG_W'(-prod_reg) : MAG_W'(prod_reg);
        if (neg_reg)
        begin
            val = {1'b0, start_reg} - {1'b0, div_rsp.quotient} - (ANG_W+1)'(div_rsp.rem_nz);
        end
        else
        begin
            val = {1'b0, start_reg} + {1'b0, div_rsp.quotient};
        end

        state_next     = state_reg;
        moving_next    = moving_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        step_next      = step_reg;
        total_next     = total_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        pend_next      = pend_reg;
        start_next     = start_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        add_en         = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = mem_servo_reg[cur];
        ram_wdata      = mem_target_reg[cur];
        ram_raddr      = mem_servo_reg[cur];
        div_req        = '{start: 1'b0, dividend: mag, divisor: total_reg};
        cmd_stall      = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = cmd_srv;
                if (accept)
                begin
                    if (moving_reg)
                    begin
                        if (cmd_data.command == CMD_TICK)
                        begin
                            step_next = step_inc;
                            ptr_next  = '0;
                            if (count_reg != '0)
                            begin
                                state_next = ST_RD;
                            end
                            else if (step_inc >= total_reg)
                            begin
                                moving_next = 1'b0;
                                step_next   = '0;
                                total_next  = '0;
                            end
                        end
                    end
                    else
                    begin
                        unique case (cmd_data.command)
                            CMD_SET:
                            begin
                                if (idx_ok)
                                begin
                                    ram_we     = 1'b1;
                                    ram_waddr  = cmd_srv;
                                    ram_wdata  = cmd_data.angle;
                                    pend_next  = '{out_servo: cmd_data.servo_index,
                                                   out_angle: cmd_data.angle,
                                                   is_read: 1'b0, last: 1'b1};
                                    state_next = ST_PUT;
                                end
                            end
                            CMD_ADD:
                            begin
                                if (idx_ok && (count_reg < CNT_W'(GROUP_SIZE)))
                                begin
                                    add_en     = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                            end
                            CMD_START:
                            begin
                                if (cmd_data.duration_ticks <= DUR_W'(1))
                                begin
                                    ptr_next = '0;
                                    if (count_reg != '0)
                                    begin
                                        state_next = ST_JUMP;
                                    end
                                    else
                                    begin
                                        step_next  = '0;
                                        total_next = '0;
                                    end
                                end
                                else
                                begin
                                    total_next  = cmd_data.duration_ticks;
                                    step_next   = '0;
                                    moving_next = 1'b1;
                                end
                            end
                            CMD_READ:
                            begin
                                if (idx_ok)
                                begin
                                    pend_next  = '{out_servo: cmd_data.servo_index,
                                                   out_angle: '0,
                                                   is_read: 1'b1, last: 1'b1};
                                    state_next = ST_READ;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            ST_READ:
            begin
                pend_next.out_angle = rd_angle;
                state_next          = ST_PUT;
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = pend_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_RD:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                // start angle arrives from the RAM this cycle
                start_next = rd_angle;
                prod_next  = PROD_W'($signed({1'b0, step_reg}) * diff);
                neg_next   = prod_next[PROD_W-1];
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '{out_servo: IDX_W'(mem_servo_reg[cur]),
                                       out_angle: val[ANG_W-1:0],
                                       is_read: 1'b0, last: cur_last};
                    if (cur_last)
                    begin
                        ptr_next   = '0;
                        state_next = (step_reg >= total_reg) ? ST_COMMIT : ST_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_COMMIT:
            begin
                // store targets in member order so a repeated servo takes the later one
                ram_we   = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (cur_last)
                begin
                    moving_next = 1'b0;
                    count_next  = '0;
                    step_next   = '0;
                    total_next  = '0;
                    ptr_next    = '0;
                    state_next  = ST_IDLE;
                end
            end
            ST_JUMP:
            begin
                if (out_free)
                begin
                    ram_we         = 1'b1;
                    res_valid_next = 1'b1;
                    res_next       = '{out_servo: IDX_W'(mem_servo_reg[cur]),
                                       out_angle: mem_target_reg[cur],
                                       is_read: 1'b0, last: cur_last};
                    ptr_next       = ptr_reg + 1'b1;
                    if (cur_last)
                    begin
                        count_next = '0;
                        step_next  = '0;
                        total_next = '0;
                        ptr_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            moving_reg    <= 1'b0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            step_reg      <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
            pvalid_reg    <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            moving_reg    <= moving_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            step_reg      <= step_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
            rd_valid_reg  <= pvalid_reg[ram_raddr];
            if (ram_we)
            begin
                pvalid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        pend_reg  <= pend_next;
        start_reg <= start_next;
        prod_reg  <= prod_next;
        neg_reg   <= neg_next;
        if (add_en)
        begin
            mem_servo_reg[count_reg[GRP_W-1:0]]  <= cmd_srv;
            mem_target_reg[count_reg[GRP_W-1:0]] <= cmd_data.angle;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for servo_group_linear_ramp. Commands go in through a
// queue-fed driver with random gaps; every drive or read-back beat is checked
// against an in-bench model of the angle store, the pending group and the
// linear ramp. One long receiver hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sglr_pkg::*;

    // commands the block has to ignore
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam int SERVOS    = NUM_SERVOS_DEF;
    localparam int GROUP_MAX = GROUP_SIZE_DEF;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd_data  = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res_data;

    logic hold_off  = 1'b0;
    logic calm;

    cmd_t pending_cmds[$];
    res_t expected_reports[$];
    res_t want_report;

    // bench copy of the block state
    logic [ANG_W-1:0] angle_now [SERVOS];
    logic [IDX_W-1:0] grp_servo [GROUP_MAX];
    logic [ANG_W-1:0] grp_target[GROUP_MAX];
    int               grp_size;
    int               tick_count;
    int               tick_total;
    logic             in_motion;

    int   cycle_count    = 0;
    int   beats_taken    = 0;
    int   reports_seen   = 0;
    int   moves_started  = 0;
    int   mismatches     = 0;
    logic cmd_beat_taken = 1'b0;

    servo_group_linear_ramp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always #1 clk = ~clk;

    // no random idling on either side inside this window
    assign calm = (cycle_count >= 2000) && (cycle_count < 12000);

    function automatic logic [ANG_W-1:0] ramp_angle(input int from, input int to,
                                                    input int k, input int n);
        int               prod;
        int               quo;
        logic [ANG_W-1:0] val;
        prod = k * (to - from);
        quo  = prod / n;
        // round towards minus infinity
        if (prod < 0 && (prod % n) != 0)
            quo = quo - 1;
        val = ANG_W'(from + quo);
        return val;
    endfunction

    function automatic void commit_group();
        for (int i = 0; i < grp_size; i++)
            angle_now[grp_servo[i]] = grp_target[i];
        grp_size   = 0;
        tick_count = 0;
        tick_total = 0;
        in_motion  = 1'b0;
    endfunction

    function automatic void push_report(input logic [IDX_W-1:0] servo,
                                        input logic [ANG_W-1:0] ang,
                                        input logic rd, input logic fin);
        res_t r;
        r.out_servo = servo;
        r.out_angle = ang;
        r.is_read   = rd;
        r.last      = fin;
        expected_reports.push_back(r);
    endfunction

    function automatic void predict_reports(input cmd_t c);
        if (in_motion) begin
            if (c.command != CMD_TICK)
                return;
            tick_count = (tick_count + 1) % 4096;
            for (int i = 0; i < grp_size; i++)
                push_report(grp_servo[i],
                            ramp_angle(angle_now[grp_servo[i]], grp_target[i],
                                       tick_count, tick_total),
                            1'b0, i == grp_size - 1);
            if (tick_count >= tick_total)
                commit_group();
            return;
        end
        case (c.command)
            CMD_SET:
            begin
                angle_now[c.servo_index] = c.angle;
                push_report(c.servo_index, c.angle, 1'b0, 1'b1);
            end
            CMD_ADD:
            begin
                if (grp_size < GROUP_MAX) begin
                    grp_servo[grp_size]  = c.servo_index;
                    grp_target[grp_size] = c.angle;
                    grp_size++;
                end
            end
            CMD_START:
            begin
                if (c.duration_ticks <= 1) begin
                    for (int i = 0; i < grp_size; i++)
                        push_report(grp_servo[i], grp_target[i], 1'b0, i == grp_size - 1);
                    commit_group();
                end else begin
                    tick_total = c.duration_ticks;
                    tick_count = 0;
                    in_motion  = 1'b1;
                    moves_started++;
                end
            end
            CMD_READ:
                push_report(c.servo_index, angle_now[c.servo_index], 1'b1, 1'b1);
            default:
            begin
            end
        endcase
    endfunction

    task automatic queue_cmd(input logic [CMD_W-1:0] op, input int servo,
                             input int ang, input int dur);
        cmd_t c;
        c.command        = op;
        c.servo_index    = IDX_W'(servo);
        c.angle          = ANG_W'(ang);
        c.duration_ticks = DUR_W'(dur);
        pending_cmds.push_back(c);
    endtask

    function automatic int pick_angle();
        if ($urandom_range(9, 0) == 0)
            return $urandom_range(255, 181);
        return $urandom_range(180, 0);
    endfunction

    // any command at all; keep stray starts short so moves do not run away
    task automatic queue_noise();
        logic [CMD_W-1:0] op;
        op = CMD_W'($urandom_range(7, 0));
        queue_cmd(op, $urandom, $urandom, (op == CMD_START) ? $urandom_range(6, 0) : $urandom);
    endtask

    // command driver: change on the falling edge, hold until taken
    always @(negedge clk) begin
        if (rst_n) begin
            if (!cmd_valid || cmd_beat_taken) begin
                if (pending_cmds.size() != 0 && (calm || $urandom_range(99, 0) >= 17)) begin
                    cmd_data  <= pending_cmds.pop_front();
                    cmd_valid <= 1'b1;
                end else begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge clk) begin
        res_stall <= hold_off || (!calm && $urandom_range(99, 0) < 17);
    end

    // monitor: sample both channels on the rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            cycle_count++;
            cmd_beat_taken = cmd_valid && !cmd_stall;
            if (cmd_beat_taken) begin
                beats_taken++;
                predict_reports(cmd_data);
            end
            if (res_valid && !res_stall) begin
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: servo %0d angle %0d read %0b last %0b",
                                 res_data.out_servo, res_data.out_angle,
                                 res_data.is_read, res_data.last);
                end else begin
                    want_report = expected_reports.pop_front();
                    reports_seen++;
                    if (res_data.out_servo !== want_report.out_servo ||
                        res_data.out_angle !== want_report.out_angle ||
                        res_data.is_read   !== want_report.is_read   ||
                        res_data.last      !== want_report.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch at beat %0d: expected servo %0d angle %0d",
                                     reports_seen, want_report.out_servo,
                                     want_report.out_angle);
                            $display("  expected read %0b last %0b, got servo %0d angle %0d",
                                     want_report.is_read, want_report.last,
                                     res_data.out_servo, res_data.out_angle);
                            $display("  got read %0b last %0b",
                                     res_data.is_read, res_data.last);
                        end
                    end
                end
            end
        end
    end

    // long receiver hold-off while commands keep coming
    initial begin
        wait (beats_taken >= 300);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial begin
        #8_000_000;
        $display("timeout: %0d beats still expected", expected_reports.size());
        $display("servo_group_linear_ramp verification failed");
        $finish;
    end

    initial begin : stimulus
        int roll;
        int members;
        int span;
        int random_beats;
        logic [CMD_W-1:0] op;

        for (int i = 0; i < SERVOS; i++)
            angle_now[i] = '0;
        grp_size   = 0;
        tick_count = 0;
        tick_total = 0;
        in_motion  = 1'b0;

        // directed: reset value, extremes, ignored commands, group corners
        queue_cmd(CMD_READ, 0, $urandom, $urandom);
        queue_cmd(CMD_SET, 15, 180, $urandom);
        queue_cmd(CMD_SET, 0, 255, 12'hFFF);
        queue_cmd(CMD_READ, 15, 0, 0);
        queue_cmd(CMD_TICK, 9, 77, 3);
        queue_cmd(CMD_SPARE_LO, 2, 40, 5);
        queue_cmd(CMD_SPARE_HI, 15, 255, 12'hFFF);
        queue_cmd(CMD_START, 0, 0, 0);
        // empty group still runs its ticks; read is dropped while moving
        queue_cmd(CMD_START, 0, 0, 2);
        queue_cmd(CMD_READ, 15, 0, 0);
        queue_cmd(CMD_TICK, 0, 0, 0);
        queue_cmd(CMD_TICK, 0, 0, 0);
        // full group with servo 3 twice; the ninth add is dropped
        queue_cmd(CMD_ADD, 0, 0, 12'hFFF);
        queue_cmd(CMD_ADD, 3, 255, 0);
        queue_cmd(CMD_ADD, 3, 100, 0);
        queue_cmd(CMD_ADD, 15, 0, 0);
        for (int i = 0; i < 5; i++)
            queue_cmd(CMD_ADD, i + 5, pick_angle(), $urandom);
        queue_cmd(CMD_START, 0, 0, 2);
        queue_cmd(CMD_TICK, 0, 0, 0);
        queue_cmd(CMD_TICK, 0, 0, 0);
        queue_cmd(CMD_ADD, 11, 180, 0);
        queue_cmd(CMD_START, 0, 0, 1);

        // long move, both full-scale directions
        queue_cmd(CMD_SET, 4, 180, $urandom);
        queue_cmd(CMD_SET, 5, 0, $urandom);
        queue_cmd(CMD_ADD, 4, 0, $urandom);
        queue_cmd(CMD_ADD, 5, 180, $urandom);
        queue_cmd(CMD_START, $urandom, $urandom, 200);
        for (int i = 0; i < 200; i++)
            queue_cmd(CMD_TICK, $urandom, $urandom, $urandom);

        random_beats = 0;
        while (random_beats < 240) begin
            roll = $urandom_range(99, 0);
            if (roll < 45) begin
                members = (roll < 4) ? $urandom_range(10, 9) : $urandom_range(8, 0);
                for (int i = 0; i < members; i++)
                    queue_cmd(CMD_ADD, $urandom_range(15, 0), pick_angle(), $urandom);
                span = ($urandom_range(99, 0) < 20) ? $urandom_range(1, 0)
                                                    : $urandom_range(12, 2);
                queue_cmd(CMD_START, $urandom, $urandom, span);
                random_beats += members + 1;
                if (span > 1) begin
                    for (int i = 0; i < span; i++) begin
                        // stray command mid-move: must be dropped
                        if ($urandom_range(99, 0) < 15) begin
                            op = CMD_W'($urandom_range(7, 0));
                            if (op == CMD_TICK)
                                op = CMD_READ;
                            queue_cmd(op, $urandom, $urandom, $urandom);
                            random_beats++;
                        end
                        queue_cmd(CMD_TICK, $urandom, $urandom, $urandom);
                    end
                    random_beats += span;
                end
            end else if (roll < 65) begin
                members = $urandom_range(3, 1);
                for (int i = 0; i < members; i++)
                    queue_cmd(CMD_SET, $urandom_range(15, 0), pick_angle(), $urandom);
                random_beats += members;
            end else if (roll < 80) begin
                queue_cmd(CMD_READ, $urandom_range(15, 0), $urandom, $urandom);
                random_beats++;
            end else begin
                queue_noise();
                random_beats++;
            end
        end

        wait (rst_n);
        while (pending_cmds.size() != 0 || cmd_valid)
            @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        $display("covered %0d commands and %0d checked beats, %0d ramped moves started",
                 beats_taken, reports_seen, moves_started);
        $display("%0d mismatches in %0d cycles", mismatches, cycle_count);
        if (mismatches == 0)
            $display("servo_group_linear_ramp verification clean");
        else
            $display("servo_group_linear_ramp verification failed");
        $finish;
    end

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

endmodule

FILE: sim.f
rtl/sglr_pkg.sv
rtl/sglr_ram.sv
rtl/sglr_div.sv
rtl/servo_group_linear_ramp.sv
dv/tb.sv
